>>> hdl/tfn_pkg.sv
// shared widths and types for the triangle face normal pipeline
`default_nettype none
package tfn_pkg;
  localparam int VW    = 16;   // vertex coordinate
  localparam int EW    = 17;   // edge vector component
  localparam int PW    = 34;   // edge product
  localparam int NW    = 35;   // cross product component
  localparam int MW    = 34;   // cross product magnitude
  localparam int HW    = 17;   // half of a magnitude
  localparam int QW2   = 68;   // one square
  localparam int SW    = 70;   // sum of squares
  localparam int RW    = 35;   // root bits
  localparam int RMW   = 38;   // root remainder
  localparam int QW    = 15;   // quotient bits
  localparam int DW    = 36;   // divider remainder
  localparam int FRACB = 14;   // fraction bits of the normal
  localparam int SQ_STAGES  = RW;
  localparam int DIV_STAGES = QW;
  localparam logic [QW-1:0] Q_ONE = QW'(1 << FRACB);

  typedef struct packed {
    logic                   last;
    logic [2:0]             neg;
    logic [2:0][MW-1:0]     mag;
  } carry_t;

  typedef struct packed {
    logic       last;
    logic       deg;
    logic [2:0] neg;
  } tail_t;
endpackage
`default_nettype wire

>>> hdl/triangle_face_normal.sv
// triangle_face_normal: streaming unit-normal pipeline, one triangle per transfer
//
// in_tdata carries vertices A, B, C (signed Q8.8) and in_tlast marks the last
// face of a mesh. out_tdata returns the unit normal in signed Q1.14, truncated
// toward zero; out_tuser flags a degenerate triangle whose normal is zero, and
// out_tlast copies in_tlast.
// Throughput: one triangle per cycle while out_tready does not stall the output.
// The path from input transfer to out_tvalid runs through six arithmetic stages,
// a 35-stage square-root pipeline (one root bit a stage) and a 15-stage divider
// (one quotient bit a stage), plus the output register.
// All stages advance together; when out_tvalid is high and out_tready low the
// whole pipeline holds and in_tready drops, so nothing is lost or repeated.
// Reset clears every valid bit; data registers are not reset.
`default_nettype none
module triangle_face_normal
  import tfn_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z (16 bits each)
  input  wire logic [143:0] in_tdata,
  input  wire logic         in_tlast,   // last_face
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [47:0]       out_tdata,  // normal_x, normal_y, normal_z
  output logic [0:0]        out_tuser,  // degenerate
  output logic              out_tlast   // last_out
);
  logic adv;
  logic out_tvalid_r;
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // stage 1: edge vectors
  logic                 v1_r, last1_r;
  logic signed [EW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic [VW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  assign ax = in_tdata[15:0];
  assign ay = in_tdata[31:16];
  assign az = in_tdata[47:32];
  assign bx = in_tdata[63:48];
  assign by = in_tdata[79:64];
  assign bz = in_tdata[95:80];
  assign cx = in_tdata[111:96];
  assign cy = in_tdata[127:112];
  assign cz = in_tdata[143:128];

  always_ff @(posedge clk) begin
    if (adv) begin
      last1_r <= in_tlast;
      e1x_r <= {bx[VW-1], bx} - {ax[VW-1], ax};
      e1y_r <= {by[VW-1], by} - {ay[VW-1], ay};
      e1z_r <= {bz[VW-1], bz} - {az[VW-1], az};
      e2x_r <= {cx[VW-1], cx} - {ax[VW-1], ax};
      e2y_r <= {cy[VW-1], cy} - {ay[VW-1], ay};
      e2z_r <= {cz[VW-1], cz} - {az[VW-1], az};
    end
  end

  // stage 2: edge products for the cross product
  logic                 v2_r, last2_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      last2_r <= last1_r;
      p0_r <= e1y_r * e2z_r;
      p1_r <= e1z_r * e2y_r;
      p2_r <= e1z_r * e2x_r;
      p3_r <= e1x_r * e2z_r;
      p4_r <= e1x_r * e2y_r;
      p5_r <= e1y_r * e2x_r;
    end
  end

  // stage 3: cross product as sign and magnitude
  logic          v3_r;
  carry_t        c3_r;
  logic [NW-1:0] n0, n1, n2;
  logic [NW-1:0] a0, a1, a2;
  assign n0 = {p0_r[PW-1], p0_r} - {p1_r[PW-1], p1_r};
  assign n1 = {p2_r[PW-1], p2_r} - {p3_r[PW-1], p3_r};
  assign n2 = {p4_r[PW-1], p4_r} - {p5_r[PW-1], p5_r};
  assign a0 = n0[NW-1] ? (~n0 + NW'(1)) : n0;
  assign a1 = n1[NW-1] ? (~n1 + NW'(1)) : n1;
  assign a2 = n2[NW-1] ? (~n2 + NW'(1)) : n2;
  always_ff @(posedge clk) begin
    if (adv) begin
      c3_r.last   <= last2_r;
      c3_r.neg    <= {n2[NW-1], n1[NW-1], n0[NW-1]};
      c3_r.mag[0] <= a0[MW-1:0];
      c3_r.mag[1] <= a1[MW-1:0];
      c3_r.mag[2] <= a2[MW-1:0];
    end
  end

  // stage 4: squares split into partial products of 17-bit halves
  logic            v4_r;
  carry_t          c4_r;
  logic [2*HW-1:0] hh_r [0:2];
  logic [2*HW-1:0] hl_r [0:2];
  logic [2*HW-1:0] ll_r [0:2];
  genvar i;
  generate
    for (i = 0; i < 3; i++) begin : g_sq
      always_ff @(posedge clk) begin
        if (adv) begin
          hh_r[i] <= c3_r.mag[i][MW-1:HW] * c3_r.mag[i][MW-1:HW];
          hl_r[i] <= c3_r.mag[i][MW-1:HW] * c3_r.mag[i][HW-1:0];
          ll_r[i] <= c3_r.mag[i][HW-1:0] * c3_r.mag[i][HW-1:0];
        end
      end
    end
  endgenerate
  always_ff @(posedge clk) begin
    if (adv) c4_r <= c3_r;
  end

  // stage 5: assemble each square
  logic           v5_r;
  carry_t         c5_r;
  logic [QW2-1:0] sq_r [0:2];
  generate
    for (i = 0; i < 3; i++) begin : g_sqsum
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_r[i] <= {hh_r[i], {(2*HW){1'b0}}}
                   + {{(QW2-2*HW-HW-1){1'b0}}, hl_r[i], {(HW+1){1'b0}}}
                   + {{(QW2-2*HW){1'b0}}, ll_r[i]};
        end
      end
    end
  endgenerate
  always_ff @(posedge clk) begin
    if (adv) c5_r <= c4_r;
  end

  // stage 6: sum of squares
  logic          v6_r;
  carry_t        c6_r;
  logic [SW-1:0] s6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c6_r <= c5_r;
      s6_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    end
  end

  // square root: one root bit per stage
  logic [SW-1:0]  rs_r   [0:SQ_STAGES-1];
  logic [RMW-1:0] rrem_r [0:SQ_STAGES-1];
  logic [RW-1:0]  root_r [0:SQ_STAGES-1];
  carry_t         rc_r   [0:SQ_STAGES-1];
  logic           rv_r   [0:SQ_STAGES-1];

  genvar k;
  generate
    for (k = 0; k < SQ_STAGES; k++) begin : g_root
      logic [SW-1:0]  s_in;
      logic [RMW-1:0] rem_in;
      logic [RW-1:0]  root_in;
      carry_t         c_in;
      logic           v_in;
      logic [RMW-1:0] cand;
      logic [RMW-1:0] trial;
      logic           ge;
      if (k == 0) begin : g_first
        assign s_in    = s6_r;
        assign rem_in  = '0;
        assign root_in = '0;
        assign c_in    = c6_r;
        assign v_in    = v6_r;
      end else begin : g_next
        assign s_in    = rs_r[k-1];
        assign rem_in  = rrem_r[k-1];
        assign root_in = root_r[k-1];
        assign c_in    = rc_r[k-1];
        assign v_in    = rv_r[k-1];
      end
      assign cand  = {rem_in[RMW-3:0], s_in[2*(SQ_STAGES-1-k)+1 -: 2]};
      assign trial = {1'b0, root_in, 2'b01};
      assign ge    = cand >= trial;
      always_ff @(posedge clk) begin
        if (adv) begin
          rs_r[k]   <= s_in;
          rrem_r[k] <= ge ? (cand - trial) : cand;
          root_r[k] <= {root_in[RW-2:0], ge};
          rc_r[k]   <= c_in;
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          rv_r[k] <= 1'b0;
        end else if (adv) begin
          rv_r[k] <= v_in;
        end
      end
    end
  endgenerate

  // division of each magnitude by the root
  logic [RW-1:0] len;
  logic [QW-1:0] q [0:2];
  carry_t        rc_end;
  assign len    = root_r[SQ_STAGES-1];
  assign rc_end = rc_r[SQ_STAGES-1];

  generate
    for (i = 0; i < 3; i++) begin : g_div
      tfn_div_lane u_div (
        .clk (clk),
        .en  (adv),
        .mag (rc_end.mag[i]),
        .len (len),
        .q   (q[i])
      );
    end
  endgenerate

  tail_t tl_r [0:DIV_STAGES-1];
  logic  tv_r [0:DIV_STAGES-1];
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_tail
      tail_t t_in;
      logic  v_in;
      if (k == 0) begin : g_first
        assign t_in = '{last: rc_end.last, deg: (len == '0), neg: rc_end.neg};
        assign v_in = rv_r[SQ_STAGES-1];
      end else begin : g_next
        assign t_in = tl_r[k-1];
        assign v_in = tv_r[k-1];
      end
      always_ff @(posedge clk) begin
        if (adv) tl_r[k] <= t_in;
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tv_r[k] <= 1'b0;
        end else if (adv) begin
          tv_r[k] <= v_in;
        end
      end
    end
  endgenerate

  // output register: sign restore, zero normal when degenerate
  tail_t         td;
  logic [VW-1:0] nrm [0:2];
  logic [47:0]   out_tdata_r;
  logic          out_deg_r, out_last_r;
  assign td = tl_r[DIV_STAGES-1];
  generate
    for (i = 0; i < 3; i++) begin : g_sign
      assign nrm[i] = td.deg    ? '0 :
                      td.neg[i] ? (VW'(0) - {1'b0, q[i]}) : {1'b0, q[i]};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {nrm[2], nrm[1], nrm[0]};
      out_deg_r   <= td.deg;
      out_last_r  <= td.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      out_tvalid_r <= tv_r[DIV_STAGES-1];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_deg_r;
  assign out_tlast  = out_last_r;

  // a zero sum of squares comes only from a zero cross product
  a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> ((s6_r == '0) == (c6_r.mag == '0)))
    else $error("sum of squares and cross product disagree on zero");

  // final root remainder never exceeds twice the root
  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r[SQ_STAGES-1] |-> (rrem_r[SQ_STAGES-1] <= RMW'({len, 1'b0})))
    else $error("square root remainder out of range");

  // a unit normal component never exceeds one
  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tv_r[DIV_STAGES-1] && !td.deg) |->
      (q[0] <= Q_ONE && q[1] <= Q_ONE && q[2] <= Q_ONE))
    else $error("normal component above one");

  // a degenerate face leaves a zero normal
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_deg_r) |-> (out_tdata_r == '0))
    else $error("degenerate face with nonzero normal");
endmodule
`default_nettype wire

>>> hdl/tfn_div_lane.sv
// pipelined restoring divider: (mag << 14) / len, one quotient bit a stage
`default_nettype none
module tfn_div_lane
  import tfn_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [MW-1:0] mag,
  input  wire logic [RW-1:0] len,
  output logic      [QW-1:0] q
);
  logic [DW-1:0] rem_r [0:DIV_STAGES-1];
  logic [QW-1:0] q_r   [0:DIV_STAGES-1];
  logic [RW-1:0] len_r [0:DIV_STAGES-1];

  genvar j;
  generate
    for (j = 0; j < DIV_STAGES; j++) begin : g_stage
      logic [DW-1:0] rem_in;
      logic [QW-1:0] q_in;
      logic [RW-1:0] len_in;
      logic          bit_in;
      logic [DW-1:0] cand;
      logic          ge;
      if (j == 0) begin : g_first
        // numerator shifted right by the quotient width stays below len
        assign rem_in = DW'(mag[MW-1:1]);
        assign q_in   = '0;
        assign len_in = len;
        assign bit_in = mag[0];
      end else begin : g_next
        assign rem_in = rem_r[j-1];
        assign q_in   = q_r[j-1];
        assign len_in = len_r[j-1];
        assign bit_in = 1'b0;
      end
      assign cand = {rem_in[DW-2:0], bit_in};
      assign ge   = cand >= DW'(len_in);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? (cand - DW'(len_in)) : cand;
          q_r[j]   <= {q_in[QW-2:0], ge};
          len_r[j] <= len_in;
        end
      end
    end
  endgenerate

  assign q = q_r[DIV_STAGES-1];
endmodule
`default_nettype wire

>>> tb/triangle_face_normal_tb.sv
// testbench for the triangle face normal pipeline: directed and random faces
`timescale 1ns / 100ps
`default_nettype none
module triangle_face_normal_tb;
  import tfn_pkg::*;

  typedef struct packed {
    logic        last;
    logic        deg;
    logic [15:0] nz;
    logic [15:0] ny;
    logic [15:0] nx;
  } normal_t;

  localparam int LATENCY   = 57;
  localparam int IDLE_MAX  = 30000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         out_tlast;

  normal_t expected_normals[$];
  int      error_count;
  int      idle_cycles;

  triangle_face_normal dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // floor square root of a sum below 2^70
  function automatic logic [34:0] floor_root(logic [69:0] s);
    logic [34:0]  r;
    logic [34:0]  t;
    logic [69:0]  sq;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      t = r | (35'd1 << b);
      sq = 70'(t) * 70'(t);
      if (sq <= s) r = t;
    end
    return r;
  endfunction

  function automatic logic [15:0] scale(logic signed [35:0] c, logic [34:0] len);
    logic [49:0] m;
    logic [49:0] q;
    m = c < 0 ? 50'(-c) : 50'(c);
    q = (m << 14) / 50'(len);
    return c < 0 ? 16'(-q) : 16'(q);
  endfunction

  function automatic normal_t face_normal(logic [143:0] v, logic last);
    logic signed [17:0] e1[3];
    logic signed [17:0] e2[3];
    logic signed [35:0] n[3];
    logic [69:0]        s;
    logic [34:0]        len;
    normal_t            r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 18'($signed(v[48+16*i +: 16])) - 18'($signed(v[16*i +: 16]));
      e2[i] = 18'($signed(v[96+16*i +: 16])) - 18'($signed(v[16*i +: 16]));
    end
    n[0] = 36'(e1[1]) * 36'(e2[2]) - 36'(e1[2]) * 36'(e2[1]);
    n[1] = 36'(e1[2]) * 36'(e2[0]) - 36'(e1[0]) * 36'(e2[2]);
    n[2] = 36'(e1[0]) * 36'(e2[1]) - 36'(e1[1]) * 36'(e2[0]);
    s = '0;
    for (int i = 0; i < 3; i++) s += 70'($signed(n[i])) * 70'($signed(n[i]));
    len = floor_root(s);
    r.last = last;
    if (len == 0) begin
      r.deg = 1'b1;
      r.nx = '0; r.ny = '0; r.nz = '0;
    end else begin
      r.deg = 1'b0;
      r.nx = scale(n[0], len);
      r.ny = scale(n[1], len);
      r.nz = scale(n[2], len);
    end
    return r;
  endfunction

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // in_tvalid stays high after a transfer so that faces can follow back to back
  task automatic send_face(logic [143:0] v, logic last);
    int gap;
    gap = $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= v;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_normals.push_back(face_normal(v, last));
    @(negedge clk);
  endtask

  // receiver stall per result
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 19);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // result check
  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_normals.size() == 0) begin
        report("unexpected transfer", out_tdata, '0);
      end else begin
        want = expected_normals.pop_front();
        if (out_tdata[15:0] !== want.nx)
          report("normal_x", out_tdata, 48'(want.nx));
        if (out_tdata[31:16] !== want.ny)
          report("normal_y", out_tdata, 48'(want.ny));
        if (out_tdata[47:32] !== want.nz)
          report("normal_z", out_tdata, 48'(want.nz));
        if (out_tuser[0] !== want.deg)
          report("degenerate", 48'(out_tuser), 48'(want.deg));
        if (out_tlast !== want.last)
          report("last_out", 48'(out_tlast), 48'(want.last));
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("triangle_face_normal_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [143:0] face_of(logic [15:0] c[9]);
    logic [143:0] v;
    for (int i = 0; i < 9; i++) v[16*i +: 16] = c[i];
    return v;
  endfunction

  task automatic test_extremes();
    logic [15:0] c[9];
    // full-scale corners
    c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
          16'h8000, 16'h7fff, 16'h8000};
    send_face(face_of(c), 1'b0);
    c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
          16'h7fff, 16'h8000, 16'h8000};
    send_face(face_of(c), 1'b1);
    c = '{16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff,
          16'h0000, 16'h0000, 16'h8000};
    send_face(face_of(c), 1'b0);
    // axis-aligned faces, both windings, and one tilted face
    c = '{0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0};
    send_face(face_of(c), 1'b0);
    c = '{0, 0, 0, 0, 16'h0100, 0, 16'h0100, 0, 0};
    send_face(face_of(c), 1'b1);
    c = '{0, 0, 0, 0, 0, 16'h0001, 16'h0001, 0, 0};
    send_face(face_of(c), 1'b0);
    c = '{0, 0, 0, 16'h0001, 16'h0001, 16'h0001, 16'hffff, 16'h0001, 0};
    send_face(face_of(c), 1'b0);
  endtask

  task automatic test_degenerate();
    logic [15:0] c[9];
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_face(face_of(c), 1'b0);
    c = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
          16'h8000, 16'h8000, 16'h8000};
    send_face(face_of(c), 1'b1);
    // collinear points
    c = '{16'h0010, 16'h0020, 16'h0030, 16'h0020, 16'h0040, 16'h0060,
          16'h0030, 16'h0060, 16'h0090};
    send_face(face_of(c), 1'b0);
    c = '{16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff};
    send_face(face_of(c), 1'b1);
    // two vertices coincide
    c = '{16'h1234, 16'hfedc, 16'h0042, 16'h1234, 16'hfedc, 16'h0042,
          16'h7000, 16'h9000, 16'h0001};
    send_face(face_of(c), 1'b0);
  endtask

  task automatic test_random_faces(int count);
    logic [143:0] v;
    logic [15:0]  base;
    int           mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) v[16*i +: 16] = 16'($urandom);
      if (mode < 3) begin
        // small faces around a random point
        for (int i = 3; i < 9; i++) begin
          base = v[16*(i % 3) +: 16];
          v[16*i +: 16] = base + 16'($urandom_range(0, 6)) - 16'd3;
        end
      end else if (mode == 3) begin
        // C = A + 2 (B - A), collinear unless the 16-bit sum wraps
        for (int i = 0; i < 3; i++)
          v[96+16*i +: 16] = v[16*i +: 16] + 16'(2 * (v[48+16*i +: 16] - v[16*i +: 16]));
        if ($urandom_range(0, 1)) v[96 +: 48] = v[48 +: 48];
      end else if (mode == 4) begin
        for (int i = 0; i < 9; i++)
          v[16*i +: 16] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      end
      send_face(v, 1'($urandom));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_degenerate();
    test_random_faces(1250);
    in_tvalid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("triangle_face_normal_tb: done, clean");
    end else begin
      $display("triangle_face_normal_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
hdl/tfn_pkg.sv
hdl/tfn_div_lane.sv
hdl/triangle_face_normal.sv
tb/triangle_face_normal_tb.sv
